@@ sv/assert_macros.svh @@
// Assertion macros shared by the sampler RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ sv/mns_pkg.sv @@
// Shared constants, control word and status types for the note sampler.
// Depends on nothing; used by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package mns_pkg;

	localparam int NUM_DEGREES = 7;
	localparam int COUNT_BITS  = 16;

	localparam int NOTE_W   = 3;
	localparam int SEED_W   = 31;
	localparam int APB_DW   = 32;
	localparam int PADDR_W  = 3;

	localparam int DEG_W    = (NUM_DEGREES > 1) ? $clog2(NUM_DEGREES) : 1;
	localparam int CNT_W    = $clog2(NUM_DEGREES + 1);
	localparam int TBL_SIZE = NUM_DEGREES * NUM_DEGREES * NUM_DEGREES;
	localparam int TBL_AW   = $clog2(TBL_SIZE);
	localparam int SUM_W    = COUNT_BITS + $clog2(NUM_DEGREES);

	// Park-Miller multiplier and modulus 2^31-1
	localparam int PM_MULT   = 16807;
	localparam int PM_MULT_W = 15;
	localparam logic [SEED_W-1:0] PM_MOD     = {SEED_W{1'b1}};
	localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1223);

	// Shared multiplier: 31 bits by the wider of the row sum and the PM constant
	localparam int MUL_B_W = (SUM_W > PM_MULT_W) ? SUM_W : PM_MULT_W;
	localparam int PROD_W  = SEED_W + MUL_B_W;

	// Scale divisor 2^31-2 = 2*(2^30-1): halve, then fold by 2^30 == 1
	localparam int T_W     = PROD_W - 1;
	localparam int FOLD_SH = 30;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CLEAR,
		OP_GEN_INIT,
		OP_RNG_FOLD,
		OP_SCAN_SUM,
		OP_SCALE_MUL,
		OP_DIV_INIT,
		OP_DIV_FOLD,
		OP_DIV_FIX,
		OP_SCAN_PICK,
		OP_EMIT,
		OP_LEARN_RD,
		OP_LEARN_WR
	} dp_op_t;

	typedef enum logic [2:0] {
		SEQ_NEXT,
		SEQ_GOTO,
		SEQ_DISPATCH,
		SEQ_LOOP_CLR,
		SEQ_LOOP_SCAN,
		SEQ_LOOP_FOLD,
		SEQ_WAIT_EMIT
	} seq_op_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		dp_op_t  op;
		seq_op_t seq;
		step_t   target;
	} ucode_t;

	typedef struct packed {
		logic clr_more;
		logic scan_more;
		logic fold_more;
		logic emit_wait;
		logic start_gen;
		logic start_learn;
	} dp_status_t;

	function automatic logic [TBL_AW-1:0] tbl_addr(
		input logic [DEG_W-1:0] older,
		input logic [DEG_W-1:0] prev,
		input logic [DEG_W-1:0] nxt
	);
		return TBL_AW'((int'(older) * NUM_DEGREES + int'(prev)) * NUM_DEGREES + int'(nxt));
	endfunction

endpackage

@@ sv/markov_note_sampler.sv @@
// Top level of the second-order Markov note sampler: register port, sequencer
// and datapath. Depends on mns_pkg, mns_sequencer and mns_datapath.
`timescale 1ns / 1ps

// markov_note_sampler keeps a count for every (older, previous, next) triple of
// scale degrees, a two-note history and a Park-Miller generator. A learn request
// (req_type 0) bumps the count for the current history and note_degree, saturating
// at the count width, and shifts the note into the history; a learn with a degree
// beyond the scale is taken and dropped without effect. A generate request
// (req_type 1) steps the generator, scales the draw exactly onto the row sum of the
// current history and returns on next_degree the first degree whose running sum
// reaches it; that degree also enters the history. After reset the block sets every
// count to one and holds in_stall high meanwhile; seed writes are taken as usual.
// A learn request runs a read step and a write step on the count memory. A generate
// request runs init, generator fold, row-sum scan, scaling multiply, divider init,
// one or more divider folds, fix, pick scan and emit: the single read port of the
// count memory is swept twice, once for the row sum and once for the pick. The next
// request is taken while a result still waits on a stalled output.

module markov_note_sampler (
	input  logic                         clk,
	input  logic                         arst_n,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mns_pkg::PADDR_W-1:0]  paddr,
	input  logic [mns_pkg::APB_DW-1:0]   pwdata,
	output logic [mns_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [mns_pkg::NOTE_W-1:0]   note_degree,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mns_pkg::NOTE_W-1:0]   next_degree
);
	import mns_pkg::*;

	// register index lives in paddr[2]
	localparam logic REG_RNG_SEED = 1'b0;

	ucode_t            ctl;
	dp_status_t        status;
	logic [SEED_W-1:0] seed_q;
	logic              cfg_wr;
	logic              seed_sel;
	logic              seed_load;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign seed_sel  = (paddr[2] == REG_RNG_SEED);
	assign seed_load = cfg_wr && seed_sel;
	assign prdata    = seed_sel ? APB_DW'(seed_q) : '0;

	// hold the last written seed for read-back; the datapath loads it on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_load) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	mns_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	mns_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.status      (status),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.note_degree (note_degree),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_degree (next_degree),
		.seed_load   (seed_load),
		.seed_value  (pwdata[SEED_W-1:0])
	);

endmodule

@@ sv/mns_sequencer.sv @@
// Microcode sequencer: step counter, control store and jump logic.
// Depends on mns_pkg; drives the control word of mns_datapath.
`timescale 1ns / 1ps

module mns_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  mns_pkg::dp_status_t status,
	output mns_pkg::ucode_t     ctl
);
	import mns_pkg::*;

	localparam step_t S_CLEAR  = step_t'(0);
	localparam step_t S_IDLE   = step_t'(1);
	localparam step_t S_G_INIT = step_t'(2);
	localparam step_t S_G_RNG  = step_t'(3);
	localparam step_t S_G_SUM  = step_t'(4);
	localparam step_t S_G_MUL  = step_t'(5);
	localparam step_t S_G_DIV  = step_t'(6);
	localparam step_t S_G_FOLD = step_t'(7);
	localparam step_t S_G_FIX  = step_t'(8);
	localparam step_t S_G_PICK = step_t'(9);
	localparam step_t S_G_EMIT = step_t'(10);
	localparam step_t S_L_RD   = step_t'(11);
	localparam step_t S_L_WR   = step_t'(12);

	step_t step_q;
	step_t step_d;
	step_t step_inc;

	// control store
	always_comb begin
		unique case (step_q)
			S_CLEAR:  ctl = '{OP_CLEAR,     SEQ_LOOP_CLR,  S_IDLE};
			S_IDLE:   ctl = '{OP_IDLE,      SEQ_DISPATCH,  S_L_RD};
			S_G_INIT: ctl = '{OP_GEN_INIT,  SEQ_NEXT,      S_IDLE};
			S_G_RNG:  ctl = '{OP_RNG_FOLD,  SEQ_NEXT,      S_IDLE};
			S_G_SUM:  ctl = '{OP_SCAN_SUM,  SEQ_LOOP_SCAN, S_IDLE};
			S_G_MUL:  ctl = '{OP_SCALE_MUL, SEQ_NEXT,      S_IDLE};
			S_G_DIV:  ctl = '{OP_DIV_INIT,  SEQ_NEXT,      S_IDLE};
			S_G_FOLD: ctl = '{OP_DIV_FOLD,  SEQ_LOOP_FOLD, S_IDLE};
			S_G_FIX:  ctl = '{OP_DIV_FIX,   SEQ_NEXT,      S_IDLE};
			S_G_PICK: ctl = '{OP_SCAN_PICK, SEQ_LOOP_SCAN, S_IDLE};
			S_G_EMIT: ctl = '{OP_EMIT,      SEQ_WAIT_EMIT, S_IDLE};
			S_L_RD:   ctl = '{OP_LEARN_RD,  SEQ_NEXT,      S_IDLE};
			S_L_WR:   ctl = '{OP_LEARN_WR,  SEQ_GOTO,      S_IDLE};
			default:  ctl = '{OP_IDLE,      SEQ_GOTO,      S_IDLE};
		endcase
	end

	// jump logic
	always_comb begin
		step_inc = step_q + step_t'(1);
		unique case (ctl.seq)
			SEQ_NEXT:      step_d = step_inc;
			SEQ_GOTO:      step_d = ctl.target;
			SEQ_DISPATCH: begin
				priority if (status.start_gen)   step_d = step_inc;
				else if (status.start_learn)     step_d = ctl.target;
				else                             step_d = step_q;
			end
			SEQ_LOOP_CLR:  step_d = status.clr_more  ? step_q : step_inc;
			SEQ_LOOP_SCAN: step_d = status.scan_more ? step_q : step_inc;
			SEQ_LOOP_FOLD: step_d = status.fold_more ? step_q : step_inc;
			SEQ_WAIT_EMIT: step_d = status.emit_wait ? step_q : ctl.target;
			default:       step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLEAR;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

@@ sv/mns_datapath.sv @@
// Datapath: count memory, note history, random generator, shared multiplier,
// fold divider, scan accumulator and output register. Depends on mns_pkg
// and assert_macros.svh; steered by the control word from mns_sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mns_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mns_pkg::ucode_t             ctl,
	output mns_pkg::dp_status_t         status,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [mns_pkg::NOTE_W-1:0]  note_degree,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mns_pkg::NOTE_W-1:0]  next_degree,
	input  logic                        seed_load,
	input  logic [mns_pkg::SEED_W-1:0]  seed_value
);
	import mns_pkg::*;

	localparam logic [CNT_W-1:0]      CNT_END   = CNT_W'(NUM_DEGREES);
	localparam logic [TBL_AW-1:0]     CLR_LAST  = TBL_AW'(TBL_SIZE - 1);
	localparam logic [DEG_W-1:0]      DEG_LAST  = DEG_W'(NUM_DEGREES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt_mem [TBL_SIZE];
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic [COUNT_BITS-1:0] wr_data;
	logic [TBL_AW-1:0]     rd_addr;
	logic [TBL_AW-1:0]     wr_addr;
	logic [TBL_AW-1:0]     clr_q;
	logic                  rd_en;
	logic                  wr_en;

	logic [DEG_W-1:0]      prev_q;
	logic [DEG_W-1:0]      older_q;
	logic [DEG_W-1:0]      note_q;
	logic [DEG_W-1:0]      pick_q;
	logic [DEG_W-1:0]      rd_deg_s1;
	logic                  rd_pend_s1;
	logic                  found_q;
	logic [CNT_W-1:0]      deg_cnt_q;

	logic [SUM_W-1:0]      acc_q;
	logic [SUM_W-1:0]      x_q;
	logic [SUM_W-1:0]      run_sum;
	logic [SUM_W-1:0]      x_fix;

	logic [SEED_W-1:0]     rng_q;
	logic [SEED_W-1:0]     rng_fold;
	logic [SEED_W:0]       fold_sum;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PROD_W-1:0]     prod_d;
	logic [PROD_W-1:0]     prod_q;
	logic [T_W-1:0]        t_q;
	logic [T_W-1:0]        t_fold;
	logic [T_W-FOLD_SH-1:0] t_hi;

	logic                  out_valid_q;
	logic [NOTE_W-1:0]     out_deg_q;

	logic                  accept;
	logic                  note_ok;
	logic                  scan_op;
	logic                  scan_issue;
	logic                  emit_go;

	assign in_stall    = (ctl.op != OP_IDLE);
	assign accept      = in_valid && !in_stall;
	assign note_ok     = int'(note_degree) < NUM_DEGREES;
	assign out_valid   = out_valid_q;
	assign next_degree = out_deg_q;

	assign scan_op    = (ctl.op == OP_SCAN_SUM) || (ctl.op == OP_SCAN_PICK);
	assign scan_issue = scan_op && (deg_cnt_q != CNT_END);
	assign run_sum    = acc_q + SUM_W'(rd_data_s1);
	assign emit_go    = (ctl.op == OP_EMIT) && (!out_valid_q || !out_stall);

	assign status.clr_more    = (clr_q != CLR_LAST);
	assign status.scan_more   = scan_issue;
	assign status.fold_more   = (t_fold[T_W-1:FOLD_SH] != '0);
	assign status.emit_wait   = out_valid_q && out_stall;
	assign status.start_gen   = accept && req_type;
	assign status.start_learn = accept && !req_type && note_ok;

	// shared multiplier: PM step or row-sum scaling
	assign mul_b  = (ctl.op == OP_GEN_INIT) ? MUL_B_W'(PM_MULT) : MUL_B_W'(acc_q);
	assign prod_d = rng_q * mul_b;

	// 2^31 == 1 mod (2^31-1): add the halves, subtract once
	assign fold_sum = {1'b0, prod_q[SEED_W-1:0]} + (SEED_W + 1)'(prod_q[PROD_W-1:SEED_W]);
	assign rng_fold = (fold_sum >= {1'b0, PM_MOD}) ? SEED_W'(fold_sum - {1'b0, PM_MOD})
		: fold_sum[SEED_W-1:0];

	// 2^30 == 1 mod (2^30-1): each fold moves the high part into the quotient
	assign t_hi   = t_q[T_W-1:FOLD_SH];
	assign t_fold = T_W'(t_hi) + T_W'(t_q[FOLD_SH-1:0]);
	assign x_fix  = (t_q[FOLD_SH-1:0] == {FOLD_SH{1'b1}}) ? x_q + SUM_W'(1) : x_q;

	// memory port steering
	always_comb begin
		rd_en   = scan_issue;
		rd_addr = tbl_addr(older_q, prev_q, deg_cnt_q[DEG_W-1:0]);
		if (ctl.op == OP_LEARN_RD) begin
			rd_en   = 1'b1;
			rd_addr = tbl_addr(older_q, prev_q, note_q);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = COUNT_BITS'(1);
		if (ctl.op == OP_CLEAR) begin
			wr_en = 1'b1;
		end else if (ctl.op == OP_LEARN_WR) begin
			wr_en   = 1'b1;
			wr_addr = tbl_addr(older_q, prev_q, note_q);
			wr_data = (rd_data_s1 == COUNT_MAX) ? rd_data_s1 : rd_data_s1 + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= cnt_mem[rd_addr];
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			deg_cnt_q   <= '0;
			rd_pend_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q      <= '0;
			older_q     <= '0;
			rng_q       <= SEED_RESET;
		end else begin
			rd_pend_s1 <= scan_issue;
			if (ctl.op == OP_CLEAR) begin
				clr_q <= clr_q + TBL_AW'(1);
			end
			if (ctl.op == OP_GEN_INIT || ctl.op == OP_DIV_FIX) begin
				deg_cnt_q <= '0;
			end else if (scan_issue) begin
				deg_cnt_q <= deg_cnt_q + CNT_W'(1);
			end
			if (ctl.op == OP_DIV_FIX) begin
				found_q <= 1'b0;
			end else if (ctl.op == OP_SCAN_PICK && rd_pend_s1 && !found_q && x_q <= run_sum) begin
				found_q <= 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// shift history on a learn write or an emitted pick
			if (ctl.op == OP_LEARN_WR) begin
				older_q <= prev_q;
				prev_q  <= note_q;
			end else if (emit_go) begin
				older_q <= prev_q;
				prev_q  <= pick_q;
			end
			if (seed_load) begin
				rng_q <= seed_value;
			end else if (ctl.op == OP_RNG_FOLD) begin
				rng_q <= rng_fold;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			note_q <= DEG_W'(note_degree);
		end
		if (scan_issue) begin
			rd_deg_s1 <= deg_cnt_q[DEG_W-1:0];
		end
		if (ctl.op == OP_GEN_INIT || ctl.op == OP_SCALE_MUL) begin
			prod_q <= prod_d;
		end
		if (ctl.op == OP_GEN_INIT || ctl.op == OP_DIV_FIX) begin
			acc_q <= '0;
		end else if (scan_op && rd_pend_s1) begin
			acc_q <= run_sum;
		end
		if (ctl.op == OP_DIV_INIT) begin
			t_q <= prod_q[PROD_W-1:1];
			x_q <= '0;
		end else if (ctl.op == OP_DIV_FOLD) begin
			t_q <= t_fold;
			x_q <= x_q + SUM_W'(t_hi);
		end else if (ctl.op == OP_DIV_FIX) begin
			x_q <= x_fix;
		end
		if (ctl.op == OP_DIV_FIX) begin
			pick_q <= DEG_LAST;
		end else if (ctl.op == OP_SCAN_PICK && rd_pend_s1 && !found_q && x_q <= run_sum) begin
			pick_q <= rd_deg_s1;
		end
		if (emit_go) begin
			out_deg_q <= NOTE_W'(pick_q);
		end
	end

	`ASSERT_NEXT(a_rng_below_mod, clk, arst_n, (ctl.op == OP_RNG_FOLD) && !seed_load, rng_q != PM_MOD)
	`ASSERT_IMPLIES(a_fold_settled, clk, arst_n, ctl.op == OP_DIV_FIX, t_q[T_W-1:FOLD_SH] == '0)
	`ASSERT_IMPLIES(a_pick_fallback, clk, arst_n, (ctl.op == OP_EMIT) && !found_q, pick_q == DEG_LAST)
	`ASSERT_HOLDS(a_out_from_emit, clk, arst_n, $rose(out_valid_q) |-> $past(ctl.op == OP_EMIT))

endmodule
